// ===== sv/tcr_pkg.sv =====
// Package for the tour crossover repair block.
// Holds the field widths, the default city limit and the queue entry type.
// No dependencies.
`default_nettype none

package tcr_pkg;

  // Width of one city code and of the city count register.
  localparam int CITY_W = 6;
  localparam int CNT_W = 7;

  // Tour position counter, saturating at its top value.
  localparam int POS_W = 7;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Default number of cities that the seen map can hold.
  localparam int MAX_CITIES_DEF = 64;

  // Reset value of the city count register.
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(64);

  // One classified tour position, passed from the front to the back.
  typedef struct packed {
    logic [CITY_W-1:0] city;
    logic              in_range;
    logic              last;
  } qent_t;

endpackage

`default_nettype wire

// ===== sv/tcr_chan_if.sv =====
// Channel interfaces for the tour crossover repair block.
// One interface carries parent genes in, one carries child cities out; uses tcr_pkg.
`default_nettype none

interface tcr_in_if
  import tcr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CITY_W-1:0] gene_a;
  logic [CITY_W-1:0] gene_b;
  logic              last_in;

  modport source (output valid, output gene_a, output gene_b, output last_in, input ready);
  modport sink (input valid, input gene_a, input gene_b, input last_in, output ready);
endinterface

interface tcr_out_if
  import tcr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CITY_W-1:0] child_city;
  logic              last_out;

  modport source (output valid, output child_city, output last_out, input ready);
  modport sink (input valid, input child_city, input last_out, output ready);
endinterface

`default_nettype wire

// ===== sv/tcr_front.sv =====
// Front end of the tour crossover repair block.
// Accepts parent gene beats, tracks the tour position and picks the candidate city.
// Depends on tcr_pkg and tcr_chan_if.
`default_nettype none

module tcr_front
  import tcr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  tcr_in_if.sink                in_ch,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic             q_full,
  output logic                  q_push,
  output qent_t                 q_data
);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [CNT_W-1:0] half;
  logic [CITY_W-1:0] cand;

  // A beat is taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && !q_full;

  // Child takes parent A before the crossover point and parent B after it.
  assign half = count >> 1;
  assign cand = (CNT_W'(pos_r) < half) ? in_ch.gene_a : in_ch.gene_b;

  always_comb begin
    q_data.city = cand;
    q_data.in_range = (CNT_W'(cand) < count);
    q_data.last = in_ch.last_in;
  end

  // Position restarts after the final beat of a tour and saturates otherwise.
  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      if (in_ch.last_in) begin
        pos_nxt = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tcr_fifo.sv =====
// Two-entry queue between the front and the back of the crossover block.
// Holds classified positions so either side can stall alone; uses tcr_pkg.
`default_nettype none

module tcr_fifo
  import tcr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire qent_t push_data,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output qent_t     head
);

  qent_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full = cnt_r[1];
  assign not_empty = (cnt_r != 2'd0);
  assign head = mem_r[rd_ptr_r];

  // Occupancy follows the push and pop strobes.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tcr_back.sv =====
// Back end of the tour crossover repair block.
// Filters repeated cities with a seen map, drains unseen cities and drives results.
// Depends on tcr_pkg and tcr_chan_if.
`default_nettype none

module tcr_back
  import tcr_pkg::*;
#(
  parameter int MAX_CITIES = MAX_CITIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic             q_valid,
  input  wire qent_t            q_head,
  output logic                  q_pop,
  tcr_out_if.source             out_ch
);

  localparam int IDX_W = $clog2(MAX_CITIES);
  localparam logic [MAX_CITIES-1:0] ONE = MAX_CITIES'(1);

  // Back end states.
  localparam logic ST_TAKE = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                  state_r;
  logic                  state_nxt;
  logic [IDX_W-1:0]      scan_r;
  logic [IDX_W-1:0]      scan_nxt;
  logic [MAX_CITIES-1:0] seen_r;
  logic [MAX_CITIES-1:0] seen_nxt;
  logic                  out_valid_r;
  logic [CITY_W-1:0]     out_city_r;
  logic                  out_last_r;

  logic [MAX_CITIES-1:0] below;
  logic [MAX_CITIES-1:0] unseen;
  logic [MAX_CITIES-1:0] cand_hot;
  logic [MAX_CITIES-1:0] scan_hot;
  logic                  out_free;
  logic                  emit;
  logic [CITY_W-1:0]     emit_city;
  logic                  emit_last;
  logic                  cand_new;

  assign out_ch.valid = out_valid_r;
  assign out_ch.child_city = out_city_r;
  assign out_ch.last_out = out_last_r;
  assign out_free = !out_valid_r || out_ch.ready;

  // Cities below the current count, and those of them not yet placed.
  always_comb begin
    for (int i = 0; i < MAX_CITIES; i++) begin
      below[i] = (CNT_W'(i) < count);
    end
  end
  assign unseen = ~seen_r & below;

  assign cand_hot = q_head.in_range ? (ONE << q_head.city[IDX_W-1:0]) : '0;
  assign cand_new = ((unseen & cand_hot) != '0);
  assign scan_hot = ONE << scan_r;

  // Candidate filtering and the ascending drain of unseen cities.
  always_comb begin
    state_nxt = state_r;
    scan_nxt = scan_r;
    seen_nxt = seen_r;
    q_pop = 1'b0;
    emit = 1'b0;
    emit_city = q_head.city;
    emit_last = 1'b0;
    case (state_r)
      ST_TAKE: begin
        if (q_valid && (!cand_new || out_free)) begin
          q_pop = 1'b1;
          if (cand_new) begin
            emit = 1'b1;
            emit_last = q_head.last && ((unseen & ~cand_hot) == '0);
            seen_nxt = seen_r | cand_hot;
          end
          if (q_head.last) begin
            if ((unseen & ~cand_hot) == '0) begin
              seen_nxt = '0;
            end else begin
              state_nxt = ST_DRAIN;
              scan_nxt = '0;
            end
          end
        end
      end
      ST_DRAIN: begin
        if ((unseen & scan_hot) != '0) begin
          if (out_free) begin
            emit = 1'b1;
            emit_city = CITY_W'(scan_r);
            emit_last = ((unseen & ~scan_hot) == '0);
            if ((unseen & ~scan_hot) == '0) begin
              seen_nxt = '0;
              state_nxt = ST_TAKE;
            end else begin
              seen_nxt = seen_r | scan_hot;
              scan_nxt = scan_r + 1'b1;
            end
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_TAKE;
      end
    endcase
  end

  // Control state and the seen map.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_TAKE;
      scan_r <= '0;
      seen_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      scan_r <= scan_nxt;
      seen_r <= seen_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_city_r <= emit_city;
      out_last_r <= emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tour_crossover_repair.sv =====
// Top level of the tour crossover repair block.
// Holds the city count register and joins front, queue and back; uses tcr_pkg.
//
//   channel  | direction | beat contents
//   ---------+-----------+------------------------------------
//   in_ch    | sink      | gene_a, gene_b, last_in
//   out_ch   | source    | child_city, last_out
//   cfg_*    | write     | city count (7 bits), no read-back
//
// The front takes one tour position per cycle while the queue has room, and
// the back handles one queued position per cycle outside its drain state
// while its output is not stalled. After the final position the back scans
// the seen map one city per cycle, holding on an unseen city while stalled.
// Reset is synchronous and clears the seen map, position and all valid bits.
// A stall on out_ch holds the output register; input then stops once the
// two-entry queue fills.
`default_nettype none

module tour_crossover_repair
  import tcr_pkg::*;
#(
  parameter int MAX_CITIES = MAX_CITIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  tcr_in_if.sink                in_ch,
  tcr_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data
);

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CITIES);

  logic [CNT_W-1:0] count_r;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_valid;
  qent_t            q_data;
  qent_t            q_head;

  // City count, clamped to the seen map size on write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= (CNT_RESET > CNT_LIMIT) ? CNT_LIMIT : CNT_RESET;
    end else if (cfg_we) begin
      count_r <= (cfg_data > CNT_LIMIT) ? CNT_LIMIT : cfg_data;
    end
  end

  tcr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .count  (count_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  tcr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tcr_back #(
    .MAX_CITIES (MAX_CITIES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .count   (count_r),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== sv/tcr_checker.sv =====
// Port-level checks for the tour crossover repair block.
// Watches the top level's channels and is bound to it; uses tcr_pkg.
`default_nettype none

module tcr_checker
  import tcr_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CITY_W-1:0] child_city,
  input wire logic              last_out
);

  logic any_in_r;

  // Records whether any input beat has been taken since reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_in_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      any_in_r <= 1'b1;
    end
  end

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(child_city) && $stable(last_out))
    else $error("stalled result beat changed");

  // No result appears before any input beat has been taken.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> any_in_r)
    else $error("result without any input");

endmodule

bind tour_crossover_repair tcr_checker u_tcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .child_city (out_ch.child_city),
  .last_out   (out_ch.last_out)
);

`default_nettype wire

// ===== sim/tb_tour_crossover_repair.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tour_crossover_repair: drives parent gene beats, predicts the
// repaired child tour in place and checks every child city beat in order.
// Depends on tcr_pkg, the tcr_in_if / tcr_out_if channel interfaces and the block itself.

module tb_tour_crossover_repair;
  import tcr_pkg::*;

  localparam int CITY_LIMIT  = MAX_CITIES_DEF;
  localparam int RAND_BEATS  = 460;
  localparam int SETTLE_CYC  = 120;
  localparam int LONG_HOLD   = 300;

  // One parent position in, one child city out.
  typedef struct packed {
    logic [CITY_W-1:0] gene_a;
    logic [CITY_W-1:0] gene_b;
    logic              last_in;
  } gene_beat_t;

  typedef struct packed {
    logic [CITY_W-1:0] city;
    logic              last;
  } child_beat_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;

  tcr_in_if  gene_bus ();
  tcr_out_if child_bus ();

  tour_crossover_repair #(
    .MAX_CITIES(CITY_LIMIT)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (gene_bus),
    .out_ch  (child_bus),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // Gene beats waiting to be sent and child cities still owed by the block.
  gene_beat_t  pend_beats[$];
  child_beat_t child_q[$];

  // Predictor copy of the block state.
  logic [CNT_W-1:0]      count_reg;
  logic [CITY_LIMIT-1:0] seen_cities;
  logic [POS_W-1:0]      tour_pos;

  int errors;
  int burst_left;
  int gap_left;
  int hold_req;
  int rand_beats;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #4_000_000;
    $display("[tour_crossover_repair] ERROR");
    $finish;
  end

  // Works out the child cities that one accepted gene beat produces.
  function automatic void crossover_predict(input gene_beat_t g);
    int unsigned eff;
    int unsigned half;
    int unsigned pick;
    int          nres;
    child_beat_t r;
    eff  = (count_reg > CITY_LIMIT) ? CITY_LIMIT : count_reg;
    half = eff / 2;
    pick = (tour_pos < half) ? g.gene_a : g.gene_b;
    nres = 0;
    if (pick < eff && !seen_cities[pick]) begin
      seen_cities[pick] = 1'b1;
      child_q.insert(child_q.size(), '{city: pick[CITY_W-1:0], last: 1'b0});
      nres++;
    end
    if (g.last_in) begin
      // Fill in every city still missing, in ascending order.
      for (int c = 0; c < eff; c++) begin
        if (!seen_cities[c]) begin
          seen_cities[c] = 1'b1;
          child_q.insert(child_q.size(), '{city: c[CITY_W-1:0], last: 1'b0});
          nres++;
        end
      end
      if (nres > 0) begin
        r = child_q.pop_back();
        r.last = 1'b1;
        child_q.insert(child_q.size(), r);
      end
      seen_cities = '0;
      tour_pos    = '0;
    end else if (tour_pos != POS_MAX) begin
      tour_pos = tour_pos + 1'b1;
    end
  endfunction

  // Sender: offers queued beats in bursts with random gaps, holding each beat until taken.
  always @(posedge clk) begin : gene_driver
    logic       drive_v;
    gene_beat_t nxt;
    drive_v = 1'b0;
    nxt     = '0;
    if (!rst_n) begin
      drive_v = 1'b0;
    end else if (gene_bus.valid && !gene_bus.ready) begin
      drive_v = 1'b1;
      nxt     = pend_beats[0];
    end else begin
      if (gene_bus.valid) begin
        crossover_predict(pend_beats.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend_beats.size() > 0) begin
        drive_v = 1'b1;
        nxt     = pend_beats[0];
      end
    end
    gene_bus.valid   <= drive_v;
    gene_bus.gene_a  <= nxt.gene_a;
    gene_bus.gene_b  <= nxt.gene_b;
    gene_bus.last_in <= nxt.last_in;
  end

  // Receiver: changes its stall pattern now and then, and takes a long hold-off on request.
  always @(posedge clk) begin : child_receiver
    logic     nready;
    rx_mode_e rx_mode;
    int       phase_left;
    int       hold_left;
    int       hold_seen;
    int       cyc;
    nready = 1'b1;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (phase_left == 0) begin
      rx_mode    = rx_mode_e'($urandom_range(0, 2));
      phase_left = $urandom_range(32, 200);
    end else begin
      phase_left--;
    end
    cyc++;
    if (hold_left > 0) begin
      hold_left--;
      nready = 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   nready = 1'b1;
        RX_RANDOM: nready = ($urandom_range(0, 3) != 0);
        default:   nready = ((cyc % 7) < 4);
      endcase
    end
    child_bus.ready <= nready;
  end

  // Checker: compares each child city beat with the oldest prediction.
  always @(posedge clk) begin : child_monitor
    child_beat_t want;
    if (rst_n && child_bus.valid && child_bus.ready) begin
      if (child_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got city %0d last %0b",
                 $time, child_bus.child_city, child_bus.last_out);
      end else begin
        want = child_q.pop_front();
        if (child_bus.child_city !== want.city || child_bus.last_out !== want.last) begin
          errors++;
          $display("%0t: mismatch, expected city %0d last %0b, got city %0d last %0b",
                   $time, want.city, want.last, child_bus.child_city, child_bus.last_out);
        end
      end
    end
  end

  task automatic push_beat(input int a, input int b, input bit lst);
    pend_beats.insert(pend_beats.size(),
                      '{gene_a: a[CITY_W-1:0], gene_b: b[CITY_W-1:0], last_in: lst});
  endtask

  // Waits until every beat is sent and every child city has come, then lets the block settle.
  task automatic settle();
    while (pend_beats.size() != 0 || gene_bus.valid || child_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_count(input int v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v[CNT_W-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    count_reg = v[CNT_W-1:0];
  endtask

  // Random permutation of 0..n-1.
  task automatic fill_perm(output int p[CITY_LIMIT], input int n);
    int j;
    int tmp;
    for (int i = 0; i < CITY_LIMIT; i++) p[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      tmp  = p[i];
      p[i] = p[j];
      p[j] = tmp;
    end
  endtask

  // Queues one tour: mostly two proper parent permutations, spiced with
  // random cities and repeats, and sometimes of the wrong length.
  task automatic queue_tour(input int eff, input int len);
    int perm_a[CITY_LIMIT];
    int perm_b[CITY_LIMIT];
    int a;
    int b;
    int pa;
    int pb;
    int r;
    fill_perm(perm_a, eff);
    fill_perm(perm_b, eff);
    pa = 0;
    pb = 0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (eff > 0 && r < 80) begin
        a = perm_a[i % eff];
        b = perm_b[i % eff];
      end else if (r < 90 || i == 0) begin
        a = $urandom_range(0, 63);
        b = $urandom_range(0, 63);
      end else begin
        a = pa;
        b = pb;
      end
      push_beat(a, b, i == len - 1);
      pa = a;
      pb = b;
      if (eff > 0) rand_beats++;
    end
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(2, 16);
    if (r < 80) return $urandom_range(17, 63);
    if (r < 92) return CITY_LIMIT;
    if (r < 95) return 2;
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 1;
      2:       return $urandom_range(65, 126);
      default: return 127;
    endcase
  endfunction

  // Main sequence: reset, directed tours, random phases, then the verdict.
  initial begin
    int cnt;
    int eff;
    int tours;
    int len;
    bit long_done;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    gene_bus.valid   = 1'b0;
    gene_bus.gene_a  = '0;
    gene_bus.gene_b  = '0;
    gene_bus.last_in = 1'b0;
    child_bus.ready  = 1'b0;
    count_reg        = CNT_RESET;
    seen_cities      = '0;
    tour_pos         = '0;
    errors           = 0;
    burst_left       = 0;
    gap_left         = 0;
    hold_req         = 0;
    rand_beats       = 0;
    long_done        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset count: one-position tour, top city from A, then the full fill-in.
    push_beat(63, 0, 1);
    settle();

    // Repeated and out-of-range candidates, crossover after two positions.
    write_count(4);
    push_beat(1, 3, 0);
    push_beat(1, 2, 0);
    push_beat(5, 63, 0);
    push_beat(6, 0, 1);
    settle();

    // Tour longer than the count whose final position emits nothing.
    write_count(2);
    push_beat(0, 9, 0);
    push_beat(9, 1, 0);
    push_beat(9, 1, 1);
    settle();

    // Count of zero: nothing is valid and nothing comes out.
    write_count(0);
    push_beat(0, 0, 0);
    push_beat(63, 63, 1);
    settle();

    // Counts above the city limit clamp to it.
    write_count(100);
    push_beat(10, 20, 0);
    push_beat(63, 63, 1);
    settle();
    write_count(127);
    push_beat(0, 63, 1);
    settle();

    // Single city: crossover point at zero, so B is used from the start.
    write_count(1);
    push_beat(0, 0, 1);
    push_beat(7, 0, 1);
    push_beat(0, 3, 1);
    settle();

    // Count changed in the middle of a tour.
    write_count(8);
    push_beat(1, 2, 0);
    push_beat(3, 4, 0);
    settle();
    write_count(4);
    push_beat(0, 1, 1);
    settle();

    // Random phases; the first one starts under a long receiver hold-off.
    hold_req++;
    while (rand_beats < RAND_BEATS) begin
      cnt = pick_count();
      write_count(cnt);
      eff   = (cnt > CITY_LIMIT) ? CITY_LIMIT : cnt;
      tours = $urandom_range(1, 3);
      for (int t = 0; t < tours; t++) begin
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, eff + 4);
        else len = (eff > 0) ? eff : 1;
        queue_tour(eff, len);
      end
      settle();
      // One tour long enough to run the position counter into saturation.
      if (!long_done && rand_beats > 200) begin
        long_done = 1'b1;
        write_count(6);
        queue_tour(6, 135);
        settle();
      end
    end

    if (errors == 0) begin
      $display("[tour_crossover_repair] OK");
    end else begin
      $display("[tour_crossover_repair] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tcr_pkg.sv
sv/tcr_chan_if.sv
sv/tcr_front.sv
sv/tcr_fifo.sv
sv/tcr_back.sv
sv/tour_crossover_repair.sv
sv/tcr_checker.sv
sim/tb_tour_crossover_repair.sv
